// ===== rtl/core/mff_pkg.sv =====
`timescale 1ns / 1ps

package mff_pkg;

  localparam int unsigned HistDepth = 16;

  localparam logic [63:0] BroadcastAddr = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ACT_BAD_CHECKSUM = 4'd0,
    ACT_DUPLICATE    = 4'd1,
    ACT_DELIVER      = 4'd2,
    ACT_DELIVER_ACK  = 4'd3,
    ACT_FORWARD      = 4'd4,
    ACT_NO_HOPS      = 4'd5,
    ACT_ACK_RECEIVED = 4'd6,
    ACT_ACK_IGNORED  = 4'd7,
    ACT_ROUTE_UPDATE = 4'd8,
    ACT_UNKNOWN      = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_BEACON = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] message_id;
    logic [63:0] sender_address;
    logic [63:0] recipient_address;
    logic [1:0]  frame_kind;
    logic [7:0]  hops_left;
    logic        checksum_ok;
  } mff_in_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  forward_hops;
  } mff_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [63:0] sender;
  } mff_entry_t;

endpackage

// ===== rtl/core/mff_cell.sv =====
`timescale 1ns / 1ps

module mff_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  mff_pkg::mff_entry_t entry_i,
  output mff_pkg::mff_entry_t entry_o,
  input  logic [31:0]        query_id_i,
  input  logic [63:0]        query_sender_i,
  output logic               hit_o
);
  import mff_pkg::*;

  logic        valid_q;
  logic [31:0] id_q;
  logic [63:0] sender_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q     <= entry_i.id;
      sender_q <= entry_i.sender;
    end
  end

  assign entry_o = '{valid: valid_q, id: id_q, sender: sender_q};
  assign hit_o   = valid_q && (id_q == query_id_i) && (sender_q == query_sender_i);

endmodule

// ===== rtl/core/mff_action.sv =====
`timescale 1ns / 1ps

module mff_action (
  input  mff_pkg::mff_in_t  item_i,
  input  logic [63:0]       own_addr_i,
  input  logic              hit_i,
  output mff_pkg::mff_out_t result_o
);
  import mff_pkg::*;

  logic for_us;
  logic bcast;

  assign for_us = (item_i.recipient_address == own_addr_i);
  assign bcast  = (item_i.recipient_address == BroadcastAddr);

  always_comb begin
    result_o.action       = ACT_UNKNOWN;
    result_o.forward_hops = 8'd0;
    if (!item_i.checksum_ok) begin
      result_o.action = ACT_BAD_CHECKSUM;
    end else if (hit_i) begin
      result_o.action = ACT_DUPLICATE;
    end else begin
      case (kind_e'(item_i.frame_kind))
        KIND_TEXT: begin
          if (bcast) begin
            result_o.action = ACT_DELIVER;
          end else if (for_us) begin
            result_o.action = ACT_DELIVER_ACK;
          end else if (item_i.hops_left != 8'd0) begin
            result_o.action       = ACT_FORWARD;
            result_o.forward_hops = item_i.hops_left - 8'd1;
          end else begin
            result_o.action = ACT_NO_HOPS;
          end
        end
        KIND_ACK: begin
          result_o.action = for_us ? ACT_ACK_RECEIVED : ACT_ACK_IGNORED;
        end
        KIND_BEACON: begin
          result_o.action = ACT_ROUTE_UPDATE;
        end
        default: begin
          result_o.action = ACT_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mesh_frame_filter_core.sv =====
// An accepted frame's result is registered and shows in the next cycle.
// Throughput: one frame per cycle unless the output stalls; all history
//   cells compare in parallel; a good non-duplicate frame moves each entry on.
// Reset (async, active low): history cells marked empty, own address zero,
//   output register empty. No clearing pass is needed.
`timescale 1ns / 1ps

module mesh_frame_filter_core #(
  parameter int unsigned HISTORY_DEPTH = mff_pkg::HistDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mff_pkg::mff_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mff_pkg::mff_out_t out_data_o
);
  import mff_pkg::*;

  logic [63:0] own_addr_q;
  logic        out_valid_q;
  mff_out_t    out_data_q;

  mff_entry_t               chain [HISTORY_DEPTH+1];
  logic [HISTORY_DEPTH-1:0] hits;
  logic                     hit;
  logic                     in_xfer;
  logic                     shift;
  mff_out_t                 result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign hit         = |hits;
  assign shift       = in_xfer && in_data_i.checksum_ok && !hit;

  assign chain[0] = '{valid: 1'b1, id: in_data_i.message_id,
                      sender: in_data_i.sender_address};

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    mff_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .shift_i        (shift),
      .entry_i        (chain[g]),
      .entry_o        (chain[g+1]),
      .query_id_i     (in_data_i.message_id),
      .query_sender_i (in_data_i.sender_address),
      .hit_o          (hits[g])
    );
  end

  mff_action u_action (
    .item_i     (in_data_i),
    .own_addr_i (own_addr_q),
    .hit_i      (hit),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        own_addr_q <= cfg_data_i;
      end
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/mff_checker.sv =====
`timescale 1ns / 1ps

module mff_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input mff_pkg::mff_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mff_pkg::mff_out_t out_data_o
);
  import mff_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_bad_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !in_data_i.checksum_ok |=>
      out_valid_o && out_data_o.action == ACT_BAD_CHECKSUM)
    else $error("bad checksum frame not dropped");

  a_fwd_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_FORWARD |-> out_data_o.forward_hops == 8'd0)
    else $error("nonzero hop count without forward");

  a_repeat_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(in_xfer) && $past(in_data_i.checksum_ok) &&
    in_xfer && in_data_i.checksum_ok &&
    in_data_i.message_id == $past(in_data_i.message_id) &&
    in_data_i.sender_address == $past(in_data_i.sender_address) |=>
      out_data_o.action == ACT_DUPLICATE)
    else $error("repeated frame not flagged duplicate");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind mesh_frame_filter_core mff_checker u_mff_checker (.*);

// ===== test/frame_action_checker.sv =====
`timescale 1ns / 1ps

module frame_action_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  mff_pkg::mff_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  mff_pkg::mff_out_t out_data_i,
  output int                mismatches_o,
  output int                pending_o
);

  import mff_pkg::*;

  logic [31:0] hist_id     [HistDepth];
  logic [63:0] hist_sender [HistDepth];
  logic        hist_valid  [HistDepth];
  int unsigned hist_wr;
  logic [63:0] node_addr;

  mff_out_t expected_actions[$];
  mff_out_t want;

  task automatic report_mismatch(input string what);
    if (mismatches_o < 100) $display("%0t ns mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  function automatic mff_out_t filter_frame(input mff_in_t f);
    mff_out_t r;
    logic     hit;
    logic     for_node;
    logic     bcast;
    r.action       = ACT_BAD_CHECKSUM;
    r.forward_hops = '0;
    if (!f.checksum_ok) return r;
    hit = 1'b0;
    for (int i = 0; i < HistDepth; i++) begin
      if (hist_valid[i] && hist_id[i] == f.message_id && hist_sender[i] == f.sender_address)
        hit = 1'b1;
    end
    if (hit) begin
      r.action = ACT_DUPLICATE;
      return r;
    end
    hist_id[hist_wr]     = f.message_id;
    hist_sender[hist_wr] = f.sender_address;
    hist_valid[hist_wr]  = 1'b1;
    hist_wr              = (hist_wr + 1) % HistDepth;
    for_node = (f.recipient_address == node_addr);
    bcast    = (f.recipient_address == BroadcastAddr);
    case (kind_e'(f.frame_kind))
      KIND_TEXT: begin
        if (for_node || bcast) begin
          r.action = bcast ? ACT_DELIVER : ACT_DELIVER_ACK;
        end else if (f.hops_left != 0) begin
          r.action       = ACT_FORWARD;
          r.forward_hops = f.hops_left - 8'd1;
        end else begin
          r.action = ACT_NO_HOPS;
        end
      end
      KIND_ACK:    r.action = for_node ? ACT_ACK_RECEIVED : ACT_ACK_IGNORED;
      KIND_BEACON: r.action = ACT_ROUTE_UPDATE;
      default:     r.action = ACT_UNKNOWN;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_id[i]     = '0;
        hist_sender[i] = '0;
        hist_valid[i]  = 1'b0;
      end
      hist_wr      = 0;
      node_addr    = '0;
      mismatches_o = 0;
      expected_actions.delete();
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) node_addr = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_actions.size() == 0) begin
          report_mismatch($sformatf("unexpected result, action %0d hops %0d",
                                    out_data_i.action, out_data_i.forward_hops));
        end else begin
          want = expected_actions.pop_front();
          if (out_data_i.action !== want.action)
            report_mismatch($sformatf("action got %0d want %0d",
                                      out_data_i.action, want.action));
          if (out_data_i.forward_hops !== want.forward_hops)
            report_mismatch($sformatf("forward_hops got %0d want %0d",
                                      out_data_i.forward_hops, want.forward_hops));
        end
      end
      if (in_valid_i && in_ready_i) expected_actions.push_back(filter_frame(in_data_i));
      pending_o = expected_actions.size();
    end
  end

endmodule

// ===== test/tb_mesh_frame_filter_core.sv =====
`timescale 1ns / 1ps

module tb_mesh_frame_filter_core;

  import mff_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [63:0] OwnA   = 64'h5A5A_0000_1234_F00D;
  localparam logic [63:0] Sender1 = 64'h0000_0001_8000_0000;
  localparam logic [63:0] Stranger = 64'h1357_9BDF_0246_8ACE;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  mff_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  mff_out_t    out_data_o;

  int          mismatches;
  int          pending;
  int unsigned cycles = 0;
  int          idle_odds = 4;
  logic [63:0] node_addr;
  logic [95:0] recent_pairs[$];

  mesh_frame_filter_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  frame_action_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic mff_in_t make_frame(input logic [31:0] id, input logic [63:0] sender,
                                         input logic [63:0] recipient, input kind_e kind,
                                         input logic [7:0] hops, input logic ok);
    mff_in_t f;
    f.message_id        = id;
    f.sender_address    = sender;
    f.recipient_address = recipient;
    f.frame_kind        = kind;
    f.hops_left         = hops;
    f.checksum_ok       = ok;
    return f;
  endfunction

  // Mostly fresh frames; some replay or nearly replay a recent (id, sender) pair
  // so that duplicates, near misses and history eviction all show up.
  function automatic mff_in_t random_frame();
    mff_in_t     f;
    logic [95:0] pair;
    int unsigned pick;
    f.message_id     = $urandom;
    f.sender_address = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (recent_pairs.size() != 0 && pick < 30) begin
      pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      f.message_id     = pair[95:64];
      f.sender_address = pair[63:0];
      if (pick < 6)
        f.message_id = f.message_id ^ (32'd1 << $urandom_range(0, 31));
      else if (pick < 10)
        f.sender_address = f.sender_address ^ (64'd1 << $urandom_range(0, 63));
    end
    case ($urandom_range(0, 3))
      0:       f.recipient_address = node_addr;
      1:       f.recipient_address = BroadcastAddr;
      2:       f.recipient_address = f.sender_address;
      default: f.recipient_address = {$urandom, $urandom};
    endcase
    f.frame_kind = kind_e'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0:       f.hops_left = 8'h00;
      1:       f.hops_left = 8'h01;
      2:       f.hops_left = 8'hFF;
      default: f.hops_left = 8'($urandom_range(0, 255));
    endcase
    f.checksum_ok = ($urandom_range(0, 9) != 0);
    return f;
  endfunction

  task automatic send_frame(input mff_in_t f);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= f;
    recent_pairs.push_back({f.message_id, f.sender_address});
    if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_own_address(input logic [63:0] value);
    node_addr = value;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] own_value;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_own_address(OwnA);
    // empty history must not match an all-zero pair
    send_frame(make_frame(32'h0, 64'h0, OwnA, KIND_TEXT, 8'h00, 1'b1));
    send_frame(make_frame(32'h0, 64'h0, OwnA, KIND_TEXT, 8'h00, 1'b1));
    // bad checksum leaves the history untouched
    send_frame(make_frame(32'h1, Sender1, OwnA, KIND_TEXT, 8'h05, 1'b0));
    send_frame(make_frame(32'h1, Sender1, OwnA, KIND_TEXT, 8'h05, 1'b1));
    send_frame(make_frame(32'h2, Sender1, BroadcastAddr, KIND_TEXT, 8'h05, 1'b1));
    send_frame(make_frame(32'h3, Sender1, Stranger, KIND_TEXT, 8'hFF, 1'b1));
    send_frame(make_frame(32'h4, Sender1, Stranger, KIND_TEXT, 8'h01, 1'b1));
    send_frame(make_frame(32'h5, Sender1, Stranger, KIND_TEXT, 8'h00, 1'b1));
    send_frame(make_frame(32'h6, Sender1, OwnA, KIND_ACK, 8'h03, 1'b1));
    send_frame(make_frame(32'h7, Sender1, Stranger, KIND_ACK, 8'h03, 1'b1));
    send_frame(make_frame(32'h8, Sender1, Stranger, KIND_BEACON, 8'h03, 1'b1));
    send_frame(make_frame(32'h9, Sender1, Stranger, KIND_OTHER, 8'h03, 1'b1));
    send_frame(make_frame(32'hFFFF_FFFF, BroadcastAddr, BroadcastAddr, KIND_TEXT,
                          8'hFF, 1'b1));
    send_frame(make_frame(32'hFFFF_FFFF, BroadcastAddr, Stranger, KIND_BEACON,
                          8'h00, 1'b1));
    // same id, other sender: not a duplicate
    send_frame(make_frame(32'h5, Stranger, Stranger, KIND_TEXT, 8'h00, 1'b1));
    wait_idle();

    // own address all ones: broadcast is also unicast to this node
    write_own_address(BroadcastAddr);
    send_frame(make_frame(32'h10, Sender1, BroadcastAddr, KIND_TEXT, 8'h07, 1'b1));
    send_frame(make_frame(32'h11, Sender1, BroadcastAddr, KIND_ACK, 8'h07, 1'b1));
    send_frame(make_frame(32'h12, Sender1, Stranger, KIND_ACK, 8'h07, 1'b1));
    send_frame(make_frame(32'h13, Sender1, 64'h0, KIND_TEXT, 8'h00, 1'b1));

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0:       own_value = '0;
        2:       own_value = '1;
        3:       own_value = {$urandom, 32'h0};
        default: own_value = {$urandom, $urandom};
      endcase
      write_own_address(own_value);
      if (p == 4) idle_odds = 0;
      for (int n = 0; n < 250; n++) begin
        if (p != 4 && n % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       idle_odds = 0;
            1:       idle_odds = 2;
            2:       idle_odds = 5;
            default: idle_odds = 12;
          endcase
        end
        send_frame(random_frame());
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
